// File: hw/rtl/cpr_pkg.sv
// Shared types and constants for the colour palette RAM port.
// Command codes and the request and result word layouts; no dependencies.
package cpr_pkg;

	localparam int PALETTE_COUNT       = 8;
	localparam int COLOURS_PER_PALETTE = 4;
	localparam logic [7:0] PAL_MASK    = 8'((1 << PALETTE_COUNT) - 1);

	typedef enum logic [1:0] {
		CMD_INDEX_WR = 2'd0,
		CMD_DATA_WR  = 2'd1,
		CMD_READ     = 2'd2,
		CMD_FLUSH    = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic       bank_select;
		logic [7:0] write_value;
	} req_word_t;

	typedef struct packed {
		logic [7:0] data_value;
		logic [7:0] index_value;
		logic [2:0] palette_out;
		logic [1:0] colour_out;
		logic [4:0] red;
		logic [4:0] green;
		logic [4:0] blue;
		logic       colour_valid;
		logic       last;
	} res_word_t;

endpackage

// File: hw/rtl/color_palette_ram_port_core.sv
// Colour palette RAM port: two 64-byte palette banks with auto-increment index.
// Depends on cpr_pkg for command codes and the request and result words.
//
// A command is taken when start is high and busy is low; each result word is
// shown for one cycle with done high, and the receiver cannot stall. The
// palettes sit in one 64 x 16-bit synchronous RAM (bank, palette, colour)
// with a registered read; per-word valid bits make unwritten words read
// as zero, so no clearing pass is needed after reset. An index write or read
// passes S_RDIDX and S_RESP before the next accept; a data write does so twice
// (read, merge and write back, then re-read at the new index). A flush scans
// palette positions up to the last dirty one, then drains in S_DRAIN; one colour
// read per cycle on the RAM port while a dirty palette is read.
module color_palette_ram_port_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cpr_pkg::req_word_t request,
	output logic              busy,
	output logic              done,
	output cpr_pkg::res_word_t result
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDIDX,
		S_RESP,
		S_FLUSH,
		S_DRAIN
	} state_t;

	state_t             state_q;
	cpr_pkg::cmd_t      cmd_q;
	logic               bank_q;
	logic [7:0]         val_q;
	logic [7:0]         idx_q   [2];
	logic [7:0]         dirty_q [2];
	logic [7:0]         scan_q;
	logic [2:0]         pal_q;
	logic [1:0]         col_q;
	logic [7:0]         data_q;
	logic               done_q;
	cpr_pkg::res_word_t result_q;
	logic               iss_s1;
	logic [2:0]         pal_s1;
	logic [1:0]         col_s1;
	logic               last_s1;

	logic [15:0]        mem [64];
	logic [63:0]        wv_q;
	logic [15:0]        rdata_q;
	logic               rvalid_q;

	logic [7:0]         idx_cur;
	logic [5:0]         raddr;
	logic [5:0]         waddr;
	logic [15:0]        rword;
	logic [7:0]         old_byte;
	logic [15:0]        wdata;
	logic               mem_we;
	logic [7:0]         scan_rest;
	logic               accept;
	logic               flush_any;
	logic               resp_go;
	logic               col_go;
	cpr_pkg::res_word_t resp_word;
	cpr_pkg::res_word_t col_word;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign result    = result_q;
	assign idx_cur   = idx_q[bank_q];
	assign raddr     = (state_q == S_FLUSH) ? {bank_q, pal_q, col_q} : {bank_q, idx_cur[5:1]};
	assign waddr     = {bank_q, idx_cur[5:1]};
	assign rword     = rvalid_q ? rdata_q : 16'h0000;
	assign old_byte  = idx_cur[0] ? rword[15:8] : rword[7:0];
	assign wdata     = idx_cur[0] ? {val_q, rword[7:0]} : {rword[15:8], val_q};
	assign mem_we    = (state_q == S_RESP) && (cmd_q == cpr_pkg::CMD_DATA_WR);
	assign scan_rest = scan_q & ~(8'd1 << pal_q);
	assign flush_any = (dirty_q[bank_q] & cpr_pkg::PAL_MASK) != 8'h00;
	assign resp_go   = (state_q == S_RESP) && (cmd_q != cpr_pkg::CMD_DATA_WR) &&
		!((cmd_q == cpr_pkg::CMD_FLUSH) && flush_any);
	assign col_go    = (state_q == S_FLUSH) && scan_q[pal_q];

	always_comb begin
		resp_word              = '0;
		resp_word.data_value   = old_byte;
		resp_word.index_value  = idx_cur;
		resp_word.last         = 1'b1;
		col_word               = '0;
		col_word.data_value    = data_q;
		col_word.index_value   = idx_cur;
		col_word.palette_out   = pal_s1;
		col_word.colour_out    = col_s1;
		col_word.red           = rword[4:0];
		col_word.green         = rword[9:5];
		col_word.blue          = rword[14:10];
		col_word.colour_valid  = 1'b1;
		col_word.last          = last_s1;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rdata_q  <= mem[raddr];
		rvalid_q <= wv_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			idx_q[0]   <= 8'h00;
			idx_q[1]   <= 8'h00;
			dirty_q[0] <= 8'h00;
			dirty_q[1] <= 8'h00;
			wv_q       <= '0;
			done_q     <= 1'b0;
			iss_s1     <= 1'b0;
		end else begin
			done_q <= resp_go || iss_s1;
			iss_s1 <= col_go;
			if (resp_go) begin
				result_q <= resp_word;
			end else if (iss_s1) begin
				result_q <= col_word;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q  <= cpr_pkg::cmd_t'(request.command);
						bank_q <= request.bank_select;
						val_q  <= request.write_value;
						if (cpr_pkg::cmd_t'(request.command) == cpr_pkg::CMD_INDEX_WR) begin
							idx_q[request.bank_select] <= request.write_value;
						end
						state_q <= S_RDIDX;
					end
				end
				S_RDIDX: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					case (cmd_q)
						cpr_pkg::CMD_DATA_WR: begin
							wv_q[waddr] <= 1'b1;
							if (old_byte != val_q) begin
								dirty_q[bank_q][idx_cur[5:3]] <= 1'b1;
							end
							if (idx_cur[7]) begin
								idx_q[bank_q] <= {2'b11, idx_cur[5:0] + 6'd1};
							end
							cmd_q   <= cpr_pkg::CMD_READ;
							state_q <= S_RDIDX;
						end
						cpr_pkg::CMD_FLUSH: begin
							data_q          <= old_byte;
							scan_q          <= dirty_q[bank_q] & cpr_pkg::PAL_MASK;
							dirty_q[bank_q] <= 8'h00;
							pal_q           <= 3'd0;
							col_q           <= 2'd0;
							if (flush_any) begin
								state_q <= S_FLUSH;
							end else begin
								state_q <= S_IDLE;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_FLUSH, S_DRAIN: begin
					if (state_q == S_DRAIN) begin
						state_q <= S_IDLE;
					end else if (scan_q[pal_q]) begin
						pal_s1  <= pal_q;
						col_s1  <= col_q;
						last_s1 <= (col_q == 2'd3) && (scan_rest == 8'h00);
						col_q   <= col_q + 2'd1;
						if (col_q == 2'd3) begin
							scan_q <= scan_rest;
							pal_q  <= pal_q + 3'd1;
							if (scan_rest == 8'h00) begin
								state_q <= S_DRAIN;
							end
						end
					end else begin
						pal_q <= pal_q + 3'd1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a command in progress");

	a_issue_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		iss_s1 |-> (state_q == S_FLUSH || state_q == S_DRAIN))
		else $error("colour read outstanding outside flush");

	a_write_only_on_data: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> $past(state_q) == S_RDIDX)
		else $error("RAM write-back without a preceding read");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command accepted but block not busy");

endmodule

// File: tb/color_palette_ram_port_core_test.sv
// Testbench for color_palette_ram_port_core: directed and random palette commands,
// each result word checked field by field against an in-bench model of both banks.
// Depends on cpr_pkg and the core RTL only.
module color_palette_ram_port_core_test;
	import cpr_pkg::*;

	localparam bit         BANK_BG      = 1'b0;
	localparam bit         BANK_OBJ     = 1'b1;
	localparam logic [7:0] AUTO_INC     = 8'h80;
	localparam logic [7:0] IDX_BIT6     = 8'h40;
	localparam int         WORD_TARGET  = 400;
	localparam int         STALL_LIMIT  = 1000;
	localparam int         DRAIN_CYCLES = 40;
	localparam int         PRINT_CAP    = 100;

	logic       clk    = 1'b0;
	logic       arst_n = 1'b0;
	logic       start  = 1'b0;
	req_word_t  request = '0;
	logic       busy;
	logic       done;
	res_word_t  result;

	req_word_t  pending_words[$];
	res_word_t  palette_results_due[$];
	res_word_t  due_word;

	logic [7:0] bank_mem[2][64];
	logic [7:0] bank_index[2];
	logic [7:0] bank_dirty[2];

	int gap_left     = 0;
	int calm_left    = 0;
	int stall_cycles = 0;
	int error_count  = 0;
	int words_seen   = 0;
	bit timed_out    = 1'b0;

	color_palette_ram_port_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	initial forever #10 clk = ~clk;

	task automatic log_error(input string msg);
		if (error_count < PRINT_CAP)
			$display("ERROR: %s", msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input int got_v, input int want_v);
		if (got_v != want_v)
			log_error($sformatf("word %0d: %s got 0x%0h expected 0x%0h",
				words_seen, name, got_v, want_v));
	endtask

	// Applies one command to the bank model and queues the words it produces.
	task automatic compute_palette_results(input req_word_t w);
		res_word_t  r;
		int         b;
		int         total;
		int         k;
		logic [5:0] a;
		logic [5:0] base;
		logic [15:0] cw;
		b = w.bank_select;
		total = 0;
		k = 0;
		case (cmd_t'(w.command))
			CMD_INDEX_WR: bank_index[b] = w.write_value;
			CMD_DATA_WR: begin
				a = bank_index[b][5:0];
				if (bank_mem[b][a] != w.write_value)
					bank_dirty[b][a[5:3]] = 1'b1;
				bank_mem[b][a] = w.write_value;
				if (bank_index[b][7])
					bank_index[b] = {2'b11, 6'(a + 6'd1)};
			end
			CMD_FLUSH: begin
				for (int p = 0; p < PALETTE_COUNT && p < 8; p++)
					if (bank_dirty[b][p])
						total += COLOURS_PER_PALETTE;
				for (int p = 0; p < PALETTE_COUNT && p < 8; p++) begin
					if (bank_dirty[b][p]) begin
						for (int c = 0; c < COLOURS_PER_PALETTE; c++) begin
							base = 6'(p * 8 + c * 2);
							cw = {bank_mem[b][6'(base + 6'd1)], bank_mem[b][base]};
							r = '0;
							r.data_value   = bank_mem[b][bank_index[b][5:0]];
							r.index_value  = bank_index[b];
							r.palette_out  = 3'(p);
							r.colour_out   = 2'(c);
							r.red          = cw[4:0];
							r.green        = cw[9:5];
							r.blue         = cw[14:10];
							r.colour_valid = 1'b1;
							r.last         = (k == total - 1);
							palette_results_due.push_back(r);
							k++;
						end
					end
				end
				bank_dirty[b] = '0;
			end
			default: ;
		endcase
		if (total == 0) begin
			r = '0;
			r.data_value  = bank_mem[b][bank_index[b][5:0]];
			r.index_value = bank_index[b];
			r.last        = 1'b1;
			palette_results_due.push_back(r);
		end
	endtask

	function automatic int pick_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			calm_left = $urandom_range(10, 40);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic add_word(input cmd_t c, input bit bank, input logic [7:0] v);
		req_word_t w;
		w.command     = c;
		w.bank_select = bank;
		w.write_value = v;
		pending_words.push_back(w);
	endtask

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start   <= 1'b0;
			request <= '0;
			gap_left = 0;
		end else begin
			if (start && !busy)
				compute_palette_results(request);
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_words.size() != 0) begin
					start   <= 1'b1;
					request <= pending_words.pop_front();
					gap_left = pick_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (palette_results_due.size() == 0) begin
				log_error($sformatf("word %0d arrived with nothing expected", words_seen));
			end else begin
				due_word = palette_results_due.pop_front();
				check_field("data_value",   result.data_value,   due_word.data_value);
				check_field("index_value",  result.index_value,  due_word.index_value);
				check_field("palette_out",  result.palette_out,  due_word.palette_out);
				check_field("colour_out",   result.colour_out,   due_word.colour_out);
				check_field("red",          result.red,          due_word.red);
				check_field("green",        result.green,        due_word.green);
				check_field("blue",         result.blue,         due_word.blue);
				check_field("colour_valid", result.colour_valid, due_word.colour_valid);
				check_field("last",         result.last,         due_word.last);
			end
			words_seen++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		int         kind;
		int         n_wr;
		bit         bank;
		logic [7:0] idx;
		logic [7:0] prev;

		for (int b = 0; b < 2; b++) begin
			bank_index[b] = '0;
			bank_dirty[b] = '0;
			for (int i = 0; i < 64; i++)
				bank_mem[b][i] = '0;
		end

		// reset state, empty flush, auto-increment with wrap, unchanged writes
		add_word(CMD_READ,     BANK_BG,  8'h00);
		add_word(CMD_FLUSH,    BANK_BG,  8'h00);
		add_word(CMD_INDEX_WR, BANK_BG,  AUTO_INC);
		add_word(CMD_DATA_WR,  BANK_BG,  8'hFF);
		add_word(CMD_DATA_WR,  BANK_BG,  8'h7F);
		add_word(CMD_DATA_WR,  BANK_BG,  8'h00);
		add_word(CMD_DATA_WR,  BANK_BG,  8'h00);
		add_word(CMD_INDEX_WR, BANK_BG,  8'hBF);
		add_word(CMD_DATA_WR,  BANK_BG,  8'hAA);
		add_word(CMD_READ,     BANK_BG,  8'hFF);
		add_word(CMD_FLUSH,    BANK_BG,  8'h55);
		// bit 6 without bit 7: no increment
		add_word(CMD_INDEX_WR, BANK_OBJ, IDX_BIT6 | 8'h05);
		add_word(CMD_DATA_WR,  BANK_OBJ, 8'h55);
		add_word(CMD_DATA_WR,  BANK_OBJ, 8'h55);
		add_word(CMD_READ,     BANK_OBJ, 8'h00);
		add_word(CMD_FLUSH,    BANK_OBJ, 8'h00);
		add_word(CMD_INDEX_WR, BANK_OBJ, 8'h10);
		add_word(CMD_DATA_WR,  BANK_OBJ, 8'h00);
		add_word(CMD_FLUSH,    BANK_OBJ, 8'hFF);
		add_word(CMD_INDEX_WR, BANK_BG,  8'hFF);
		add_word(CMD_DATA_WR,  BANK_BG,  8'h80);
		add_word(CMD_READ,     BANK_BG,  8'h00);
		add_word(CMD_FLUSH,    BANK_BG,  8'hFF);

		while (pending_words.size() < WORD_TARGET) begin
			kind = $urandom_range(0, 99);
			bank = $urandom_range(0, 1);
			if (kind < 3) begin
				add_word(CMD_INDEX_WR, bank, AUTO_INC | 8'($urandom_range(0, 127)));
				for (int i = 0; i < 64; i++)
					add_word(CMD_DATA_WR, bank, pick_byte());
				add_word(CMD_FLUSH, bank, pick_byte());
			end else if (kind < 75) begin
				idx = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 4) != 0)
					idx = idx | AUTO_INC;
				add_word(CMD_INDEX_WR, bank, idx);
				n_wr = $urandom_range(1, 10);
				prev = pick_byte();
				for (int i = 0; i < n_wr; i++) begin
					if ($urandom_range(0, 3) != 0)
						prev = pick_byte();
					add_word(CMD_DATA_WR, bank, prev);
					if ($urandom_range(0, 5) == 0)
						add_word(CMD_READ, bank, pick_byte());
				end
				if ($urandom_range(0, 9) < 7)
					add_word(CMD_FLUSH, bank, pick_byte());
			end else begin
				add_word(cmd_t'($urandom_range(0, 3)), bank, pick_byte());
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || start || palette_results_due.size() != 0) begin
			@(posedge clk);
			if (stall_cycles >= STALL_LIMIT) begin
				timed_out = 1'b1;
				break;
			end
		end
		if (!timed_out) begin
			repeat (DRAIN_CYCLES) @(posedge clk);
			if (palette_results_due.size() != 0)
				log_error($sformatf("%0d expected words never arrived",
					palette_results_due.size()));
		end

		if (!timed_out && error_count == 0)
			$display("color_palette_ram_port_core_test: PASS");
		else
			$display("color_palette_ram_port_core_test: FAIL");
		$finish;
	end

endmodule
